[sv/sliding_window_median_filter_defines.svh]
// ----------------------------------------------------------------------------
// Sliding window median filter: assertion macros
// Concurrent assertion helpers, used by the filter's datapath module.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SWMF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SWMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/swmf_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window median filter: package
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_W     = 6;   // width of the window_length write field
    localparam int USED_W    = 6;   // width of the samples_used result field
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int LEN_RESET = 5;

    // Register index, taken from the word address bits of paddr.
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DRAIN,
        S_PICK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;    // take the word: store it, advance pointer, clear sorter
        logic issue;    // read the next window entry into the sorter
        logic pick;     // capture the upper middle value
        logic finish;   // form the median and load the output register
    } t_cmd;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } t_sts;

endpackage

[sv/swmf_ram.sv]
// ----------------------------------------------------------------------------
// Sliding window median filter: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/swmf_ctrl.sv]
// ----------------------------------------------------------------------------
// Sliding window median filter: controller
// Sequences one word through store, window read-out, sort and median pick.
// ----------------------------------------------------------------------------
module swmf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  swmf_pkg::t_sts i_sts,
    output swmf_pkg::t_cmd o_cmd
);
    import swmf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read entry is inserted into the sorter here.
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/swmf_dpath.sv]
// ----------------------------------------------------------------------------
// Sliding window median filter: datapath
// Window RAM, write pointer, insertion sorter cells and output register.
// ----------------------------------------------------------------------------
`include "sliding_window_median_filter_defines.svh"

module swmf_dpath #(
    parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    localparam int CW = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmf_pkg::CFG_W-1:0]    i_cfg_data,
    output logic [CW-1:0]                 o_len,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  swmf_pkg::t_cmd                i_cmd,
    output swmf_pkg::t_sts                o_sts,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_median,
    output logic [swmf_pkg::USED_W-1:0]   o_used
);
    import swmf_pkg::*;

    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_RST = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

    logic [CW-1:0]  r_len;
    logic [PW-1:0]  r_wp;
    logic           r_full;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  r_rd_idx;
    logic           r_rd_pend;

    logic signed [SAMPLE_BITS-1:0] r_cell [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] n_cell [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         r_cvalid;
    logic [MAX_WINDOW-1:0]         n_cvalid;
    logic [MAX_WINDOW-1:0]         w_gt;

    logic signed [SAMPLE_BITS-1:0] r_hi;
    logic signed [SAMPLE_BITS-1:0] r_med;
    logic [CW-1:0]                 r_used;
    logic                          r_out_valid;

    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_din;
    logic [CW-1:0]                 w_len_cfg;
    logic [CW-1:0]                 w_wp1;
    logic                          w_wrap;
    logic [CW-1:0]                 w_half;
    logic [CW-1:0]                 w_sel;
    logic signed [SAMPLE_BITS-1:0] w_pick;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS-1:0] w_med;

    swmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign w_din = $signed(w_rdata);

    // A length of zero acts as one; anything above the window size saturates.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_len_cfg = CW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WINDOW)) begin
            w_len_cfg = CW'(MAX_WINDOW);
        end else begin
            w_len_cfg = CW'(i_cfg_data);
        end
    end

    assign w_wp1  = CW'(r_wp) + CW'(1);
    assign w_wrap = (w_wp1 == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= CW'(LEN_RST);
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_cfg_we) begin
            r_len  <= w_len_cfg;
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.start) begin
            r_wp   <= w_wrap ? '0 : PW'(w_wp1);
            r_full <= r_full | w_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_count <= (r_full || w_wrap) ? r_len : w_wp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.issue;
            if (i_cmd.start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.issue) begin
                r_rd_idx <= r_rd_idx + PW'(1);
            end
        end
    end

    assign o_sts.last_issue = (CW'(r_rd_idx) + CW'(1) == r_count);
    assign o_sts.out_free   = !r_out_valid || i_ready;

    // Insertion sorter: cells hold an ascending run, empty cells count as
    // larger than anything, and every cell above the new word's place
    // shifts up by one.
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            w_gt[i] = !r_cvalid[i] || (r_cell[i] > w_din);
        end
        n_cell[0]   = w_gt[0] ? w_din : r_cell[0];
        n_cvalid[0] = 1'b1;
        for (int i = 1; i < MAX_WINDOW; i++) begin
            if (!w_gt[i]) begin
                n_cell[i] = r_cell[i];
            end else if (w_gt[i-1]) begin
                n_cell[i] = r_cell[i-1];
            end else begin
                n_cell[i] = w_din;
            end
            n_cvalid[i] = r_cvalid[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_cell <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (i_cmd.start) begin
            r_cvalid <= '0;
        end else if (r_rd_pend) begin
            r_cvalid <= n_cvalid;
        end
    end

    // One read port on the cells: upper middle first, lower middle next.
    assign w_half = r_count >> 1;
    assign w_sel  = i_cmd.pick ? w_half : (w_half - CW'(1));
    assign w_pick = r_cell[w_sel[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_hi <= w_pick;
        end
    end

    assign w_sum = {w_pick[SAMPLE_BITS-1], w_pick} + {r_hi[SAMPLE_BITS-1], r_hi};
    assign w_med = r_count[0] ? r_hi : SAMPLE_BITS'(w_sum >>> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_med  <= w_med;
            r_used <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_len    = r_len;
    assign o_valid  = r_out_valid;
    assign o_median = r_med;
    assign o_used   = USED_W'(r_used);

    `SWMF_ASSERT_ALWAYS(a_wp_in_window, i_clk, i_rst_n, (CW'(r_wp) < r_len),
        "write pointer outside the window")
    `SWMF_ASSERT_IMPLY(a_issue_in_range, i_clk, i_rst_n, i_cmd.issue,
        (CW'(r_rd_idx) < r_count), "window read beyond the valid count")
    `SWMF_ASSERT_IMPLY(a_sorter_filled, i_clk, i_rst_n, i_cmd.pick,
        ($countones(r_cvalid) == 32'(r_count)), "sorter fill does not match count")
    `SWMF_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_cmd.finish,
        (!r_out_valid || i_ready), "result loaded over a word not yet taken")

endmodule

[sv/sliding_window_median_filter.sv]
// ----------------------------------------------------------------------------
// Sliding window median filter: top level
// Running median over the most recent window_length signed samples.
//
// Input channel: i_valid / o_ready carry one signed sample per word.
// Output channel: o_valid / i_ready carry the median and the number of
// samples it was taken over. Each input word yields exactly one output word.
// Configuration: an APB-style port; window_length sits at byte address 0.
// Writing it resets the write pointer and restarts the fill of the window.
// Only write it while no word is in flight.
// Sequence: once a sample is accepted, the window RAM feeds the insertion
// sorter one entry per cycle until all count entries, where count is the
// number of samples used, are inserted; then the upper middle is picked,
// the median is formed and loaded into the output register, and only then
// is the next sample accepted. o_ready is high only while the block is idle.
// The output word sits in a register, so the next sample is accepted while
// a result still waits. If the receiver stalls, the following result waits
// inside the block and no further sample is taken until it moves out.
// Reset clears the pointer and fill state and sets window_length to 5.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
    parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swmf_pkg::APB_AW-1:0]   paddr,
    input  logic [swmf_pkg::APB_DW-1:0]   pwdata,
    output logic [swmf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_median_out,
    output logic [swmf_pkg::USED_W-1:0]   o_samples_used
);
    import swmf_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic          w_reg_hit;
    logic          w_cfg_we;
    logic [CW-1:0] w_len;

    assign w_reg_hit = (paddr[2] == REG_WINDOW_LENGTH) && (paddr[1:0] == 2'b00);
    assign w_cfg_we  = psel && penable && pwrite && w_reg_hit;
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? APB_DW'(w_len) : '0;

    swmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    swmf_dpath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (pwdata[CFG_W-1:0]),
        .o_len      (w_len),
        .i_sample   (i_sample_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_median   (o_median_out),
        .o_used     (o_samples_used)
    );

endmodule

[tb/sliding_window_median_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window median filter: testbench
// Drives signed samples through the valid/ready input channel and checks
// every median word against a running-median predictor kept in the bench.
// The window length is rewritten between phases, including the zero,
// saturating and out-of-field values, and both sides idle at random.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_tb;
    import swmf_pkg::*;

    localparam int SW             = SAMPLE_BITS_DEF;
    localparam int MAXW           = MAX_WINDOW_DEF;
    localparam int DRAIN_CYCLES   = MAX_WINDOW_DEF + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [SW-1:0] median;
        logic [USED_W-1:0]    used;
    } median_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [SW-1:0] i_sample_in = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [SW-1:0] o_median_out;
    logic [USED_W-1:0]    o_samples_used;

    // Predictor state: a copy of the window and its fill bookkeeping.
    logic signed [SW-1:0] hist_store [MAXW];
    int                   hist_ptr = 0;
    bit                   hist_full = 1'b0;
    int                   hist_len = LEN_RESET;

    median_result_t       pending_medians [$];
    int                   errors = 0;
    int                   quiet_cycles = 0;
    int                   rx_stall = 0;
    bit                   steady = 1'b0;

    sliding_window_median_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_in    (i_sample_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_out   (o_median_out),
        .o_samples_used (o_samples_used)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SW-1:0] draw_sample();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return SW'($urandom());
        end
        if (r < 8) begin
            // A narrow range produces many ties inside the window.
            v = int'($urandom_range(0, 12)) - 6;
            return v[SW-1:0];
        end
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh8001;
            default: return 16'sh7FFE;
        endcase
    endfunction

    function automatic void set_window_length(input logic [APB_DW-1:0] value);
        int v;
        v = int'(value[CFG_W-1:0]);
        hist_len = (v == 0) ? 1 : ((v > MAXW) ? MAXW : v);
        hist_ptr = 0;
        hist_full = 1'b0;
    endfunction

    function automatic median_result_t compute_median(input logic signed [SW-1:0] s);
        int             srt [MAXW];
        int             cnt;
        int             v;
        int             j;
        int             med;
        median_result_t r;
        if (hist_ptr >= hist_len) begin
            hist_ptr = 0;
        end
        hist_store[hist_ptr] = s;
        hist_ptr++;
        if (hist_ptr >= hist_len) begin
            hist_ptr = 0;
            hist_full = 1'b1;
        end
        cnt = hist_full ? hist_len : hist_ptr;
        for (int i = 0; i < cnt; i++) begin
            v = hist_store[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        // The arithmetic shift floors an even-count mean toward minus infinity.
        med = cnt[0] ? srt[cnt/2] : (srt[cnt/2-1] + srt[cnt/2]) >>> 1;
        r.median = med[SW-1:0];
        r.used = cnt[USED_W-1:0];
        return r;
    endfunction

    // Each task starts and ends just after a rising edge.
    task automatic send_sample(input logic signed [SW-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_ready);
        pending_medians.push_back(compute_median(s));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        set_window_length(value);
    endtask

    task automatic test_default_length();
        logic signed [SW-1:0] seq [7];
        seq = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sd100, -16'sd100};
        foreach (seq[k]) begin
            send_sample(seq[k]);
        end
    endtask

    task automatic test_length_corners();
        logic signed [SW-1:0] pair_seq [6];
        pair_seq = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sd1, 16'sd0};
        wait_drained();
        // Zero behaves as a window of one.
        write_window_length(0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd5);
        wait_drained();
        write_window_length(2);
        foreach (pair_seq[k]) begin
            send_sample(pair_seq[k]);
        end
        wait_drained();
        // Values above the maximum saturate.
        write_window_length(40);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_drained();
        // Bits above the register field are dropped.
        write_window_length(32'hFFFF_FFC3);
        send_sample(-16'sd3);
        send_sample(16'sd9);
        send_sample(16'sd2);
    endtask

    task automatic test_random_windows();
        int lengths [15];
        int n;
        lengths = '{1, 2, 3, 4, 7, 8, 16, 31, 32, 0, 50, 33, 63, 0, 0};
        lengths[13] = $urandom_range(1, 32);
        lengths[14] = $urandom_range(0, 63);
        foreach (lengths[k]) begin
            wait_drained();
            write_window_length(lengths[k]);
            steady = ($urandom_range(0, 4) == 0);
            n = 40 + $urandom_range(0, 10);
            repeat (n) send_sample(draw_sample());
        end
        steady = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        wait_drained();
        write_window_length(9);
        for (int k = 0; k < 40; k++) begin
            send_sample(draw_sample());
            if (k % 5 == 4) begin
                wait_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
            i_ready <= 1'b0;
        end else begin
            rx_stall = pick_gap();
            i_ready <= (rx_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        median_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_medians.size() == 0) begin
                errors++;
                $error("unexpected median word: median_out %0d, samples_used %0d",
                       o_median_out, o_samples_used);
            end else begin
                want = pending_medians.pop_front();
                if (o_median_out !== want.median) begin
                    errors++;
                    $error("median_out mismatch: expected %0d, actual %0d",
                           want.median, o_median_out);
                end
                if (o_samples_used !== want.used) begin
                    errors++;
                    $error("samples_used mismatch: expected %0d, actual %0d",
                           want.used, o_samples_used);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sliding_window_median_filter_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_length();
        test_length_corners();
        test_random_windows();
        test_pause_until_drained();
        wait_drained();
        if (errors == 0 && pending_medians.size() == 0) begin
            $display("sliding_window_median_filter_tb: done, clean");
        end else begin
            $display("sliding_window_median_filter_tb: done, errors");
        end
        $finish;
    end

endmodule
